### design/mbfd_pkg.sv
// Shared types and constants for the Modbus RTU frame delimiter.
// No dependencies; imported by mbfd_parser and the top level.
package mbfd_pkg;

  localparam int MAX_FRAME = 256;
  localparam int CNT_W     = 10;
  localparam int LEN_W     = 9;
  localparam int HDR_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  localparam logic [7:0] BCAST_ADDR = 8'hff;
  localparam logic [7:0] ID_FUNC    = 8'h03;

  localparam logic [CNT_W-1:0] ID_PAYLOAD         = CNT_W'(6);
  localparam logic [CNT_W-1:0] DEFAULT_PAYLOAD    = CNT_W'(6);
  localparam logic [CNT_W-1:0] COORD_SCAN_PAYLOAD = CNT_W'(4);
  localparam logic [CNT_W-1:0] ROUTE_SCAN_PAYLOAD = CNT_W'(7);

  localparam logic [HDR_W-1:0] HDR_BASIC = HDR_W'(2);
  localparam logic [HDR_W-1:0] HDR_READ  = HDR_W'(3);
  localparam logic [HDR_W-1:0] HDR_MULTI = HDR_W'(6);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COORD_MODE  = 3'd0,
    CFG_OWN_ADDR    = 3'd1,
    CFG_LOCAL_ADDR  = 3'd2,
    CFG_READ_OP     = 3'd3,
    CFG_WRITE_OP    = 3'd4,
    CFG_MULTI_OP    = 3'd5,
    CFG_SCAN_OP     = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_ADDR  = 3'd0,
    ST_FUNC  = 3'd1,
    ST_DATA  = 3'd2,
    ST_LEN   = 3'd3,
    ST_IDHI  = 3'd4,
    ST_IDLO  = 3'd5,
    ST_LENHI = 3'd6
  } parse_state_t;

  typedef enum logic [1:0] {
    DISP_LOCAL = 2'd0,
    DISP_QUEUE = 2'd1,
    DISP_RADIO = 2'd2,
    DISP_ID    = 2'd3
  } dispatch_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic       queue_busy;
  } in_req_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [7:0]       byte_index;
    logic             byte_stored;
    logic             frame_end;
    dispatch_t        dispatch;
    logic [LEN_W-1:0] frame_length;
    logic             frame_abort;
    logic [7:0]       device_id;
    logic [7:0]       product_code;
  } out_req_t;

  typedef struct packed {
    logic       coordinator_mode;
    logic [7:0] own_address;
    logic [7:0] local_address;
    logic [7:0] read_opcode;
    logic [7:0] write_opcode;
    logic [7:0] multi_write_opcode;
    logic [7:0] scan_opcode;
  } cfg_t;

endpackage

### design/mbfd_parser.sv
// Frame parse state and per-request result logic.
// Depends on mbfd_pkg; state advances when step is high.
module mbfd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  mbfd_pkg::cfg_t    cfg,
  input  mbfd_pkg::in_req_t req,
  output logic             res_valid,
  output mbfd_pkg::out_req_t res
);
  import mbfd_pkg::*;

  parse_state_t     state_r, state_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [CNT_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0] rcv_r, rcv_nxt;
  logic [HDR_W-1:0] hdr_r, hdr_nxt;
  logic             busy_r, busy_nxt;
  logic [7:0]       cap4_r, cap4_nxt;
  logic [7:0]       cap6_r, cap6_nxt;

  logic [7:0]       ch;
  logic             coord;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] rcv_inc;
  logic [CNT_W-1:0] len_exp;
  logic [HDR_W-1:0] len_hdr;
  logic [CNT_W:0]   len_total;
  logic [CNT_W-1:0] frame_len;

  assign ch        = req.rx_byte;
  assign coord     = cfg.coordinator_mode;
  assign idx       = CNT_W'(hdr_r) + rcv_r;
  assign rcv_inc   = rcv_r + CNT_W'(1);
  assign len_hdr   = coord ? HDR_MULTI : HDR_READ;
  assign len_exp   = coord ? ({2'b00, ch} + {2'b00, ch} + CNT_W'(3))
                           : ({2'b00, ch} + CNT_W'(2));
  assign len_total = (CNT_W+1)'(len_hdr) + {1'b0, len_exp};
  assign frame_len = CNT_W'(hdr_r) + exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ADDR;
      addr_r  <= '0;
      func_r  <= '0;
      exp_r   <= '0;
      rcv_r   <= '0;
      hdr_r   <= HDR_BASIC;
      busy_r  <= 1'b0;
      cap4_r  <= '0;
      cap6_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
      exp_r   <= exp_nxt;
      rcv_r   <= rcv_nxt;
      hdr_r   <= hdr_nxt;
      busy_r  <= busy_nxt;
      cap4_r  <= cap4_nxt;
      cap6_r  <= cap6_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    exp_nxt   = exp_r;
    rcv_nxt   = rcv_r;
    hdr_nxt   = hdr_r;
    busy_nxt  = busy_r;
    cap4_nxt  = cap4_r;
    cap6_nxt  = cap6_r;
    res_valid = 1'b0;
    res       = '0;

    if (req.operation == OP_TICK) begin
      if (busy_r) begin
        res_valid       = 1'b1;
        res.frame_abort = 1'b1;
        state_nxt       = ST_ADDR;
        busy_nxt        = 1'b0;
      end
    end else begin
      res_valid       = 1'b1;
      res.out_byte    = ch;
      res.byte_stored = 1'b1;
      unique case (state_r)
        ST_ADDR: begin
          addr_nxt       = ch;
          state_nxt      = ST_FUNC;
          if (coord) busy_nxt = 1'b1;
          res.byte_index = 8'd0;
        end
        ST_FUNC: begin
          func_nxt       = ch;
          rcv_nxt        = '0;
          res.byte_index = 8'd1;
          if (coord) begin
            if (ch == cfg.multi_write_opcode) begin
              hdr_nxt   = HDR_MULTI;
              state_nxt = ST_IDHI;
            end else begin
              hdr_nxt   = HDR_BASIC;
              exp_nxt   = (addr_r == BCAST_ADDR && ch == cfg.scan_opcode)
                          ? COORD_SCAN_PAYLOAD : DEFAULT_PAYLOAD;
              state_nxt = ST_DATA;
            end
          end else if (addr_r == cfg.own_address) begin
            hdr_nxt   = HDR_BASIC;
            exp_nxt   = DEFAULT_PAYLOAD;
            state_nxt = ST_DATA;
          end else if (ch == cfg.read_opcode) begin
            hdr_nxt   = HDR_READ;
            state_nxt = ST_LEN;
          end else if (ch == cfg.scan_opcode) begin
            hdr_nxt   = HDR_BASIC;
            exp_nxt   = ROUTE_SCAN_PAYLOAD;
            state_nxt = ST_DATA;
          end else if (ch == cfg.write_opcode || ch == cfg.multi_write_opcode) begin
            hdr_nxt   = HDR_BASIC;
            exp_nxt   = DEFAULT_PAYLOAD;
            state_nxt = ST_DATA;
          end else begin
            res.byte_stored = 1'b0;
            res.frame_abort = 1'b1;
            state_nxt       = ST_ADDR;
            busy_nxt        = 1'b0;
          end
        end
        ST_IDHI, ST_IDLO, ST_LENHI: begin
          unique case (state_r)
            ST_IDHI: res.byte_index = 8'd2;
            ST_IDLO: res.byte_index = 8'd3;
            default: res.byte_index = 8'd4;
          endcase
          if (!coord) begin
            res.byte_stored = 1'b0;
            res.frame_abort = 1'b1;
            state_nxt       = ST_ADDR;
            busy_nxt        = 1'b0;
          end else begin
            unique case (state_r)
              ST_IDHI: state_nxt = ST_IDLO;
              ST_IDLO: state_nxt = ST_LENHI;
              default: begin
                state_nxt = ST_LEN;
                cap4_nxt  = ch;
              end
            endcase
          end
        end
        ST_LEN: begin
          res.byte_index = 8'(len_hdr - HDR_W'(1));
          if (len_total > (CNT_W+1)'(MAX_FRAME)) begin
            res.byte_stored = 1'b0;
            res.frame_abort = 1'b1;
            state_nxt       = ST_ADDR;
            busy_nxt        = 1'b0;
          end else begin
            hdr_nxt   = len_hdr;
            exp_nxt   = len_exp;
            rcv_nxt   = '0;
            state_nxt = ST_DATA;
          end
        end
        ST_DATA: begin
          res.byte_index = idx[7:0];
          rcv_nxt        = rcv_inc;
          if (idx == CNT_W'(4)) cap4_nxt = ch;
          if (idx == CNT_W'(6)) cap6_nxt = ch;
          if (!(rcv_inc < exp_r)) begin
            res.frame_end    = 1'b1;
            res.frame_length = frame_len[LEN_W-1:0];
            state_nxt        = ST_ADDR;
            busy_nxt         = 1'b0;
            if (addr_r == BCAST_ADDR && func_r == ID_FUNC && exp_r == ID_PAYLOAD) begin
              res.dispatch     = DISP_ID;
              res.device_id    = cap4_nxt;
              res.product_code = cap6_nxt;
            end else if (coord || addr_r == cfg.local_address) begin
              res.dispatch = DISP_LOCAL;
            end else begin
              res.dispatch = req.queue_busy ? DISP_QUEUE : DISP_RADIO;
            end
          end
        end
        default: begin
          res.byte_index  = 8'd0;
          res.byte_stored = 1'b0;
          res.frame_abort = 1'b1;
          state_nxt       = ST_ADDR;
          busy_nxt        = 1'b0;
        end
      endcase
    end
  end

endmodule

### design/modbus_rtu_frame_delimiter_core.sv
// Modbus RTU frame delimiter: input register, parser, result register.
// Depends on mbfd_pkg and mbfd_parser.
// Path: input reg loads on the accepting edge; result reg then sets out_valid.
// Throughput: 1 request per cycle while out_stall does not hold a result.
// Reset: synchronous active-low; clears parse state, pipeline valids and
// restores configuration defaults.
module modbus_rtu_frame_delimiter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mbfd_pkg::in_req_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mbfd_pkg::out_req_t                 out_data,
  input  logic                               cfg_we,
  input  logic [mbfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbfd_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import mbfd_pkg::*;

  cfg_t     cfg_r;
  logic     s1_valid_r;
  in_req_t  s1_data_r;
  logic     out_valid_r;
  out_req_t out_data_r;
  logic     res_valid;
  out_req_t res;
  logic     s1_go;

  assign s1_go     = s1_valid_r && (!res_valid || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coordinator_mode   <= 1'b1;
      cfg_r.own_address        <= 8'd1;
      cfg_r.local_address      <= 8'd23;
      cfg_r.read_opcode        <= 8'd3;
      cfg_r.write_opcode       <= 8'd6;
      cfg_r.multi_write_opcode <= 8'd16;
      cfg_r.scan_opcode        <= 8'd25;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COORD_MODE: cfg_r.coordinator_mode   <= cfg_wdata[0];
        CFG_OWN_ADDR:   cfg_r.own_address        <= cfg_wdata;
        CFG_LOCAL_ADDR: cfg_r.local_address      <= cfg_wdata;
        CFG_READ_OP:    cfg_r.read_opcode        <= cfg_wdata;
        CFG_WRITE_OP:   cfg_r.write_opcode       <= cfg_wdata;
        CFG_MULTI_OP:   cfg_r.multi_write_opcode <= cfg_wdata;
        CFG_SCAN_OP:    cfg_r.scan_opcode        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_data_r <= res;
    end
  end

  mbfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .cfg       (cfg_r),
    .req       (s1_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule
